// ===== rtl/core/masked_byte_pattern_matcher_defines.svh =====
// Assertion macros for the masked byte pattern matcher
`ifndef MASKED_BYTE_PATTERN_MATCHER_DEFINES_SVH
`define MASKED_BYTE_PATTERN_MATCHER_DEFINES_SVH

// check that cons holds in the same cycle as ante
`define MBPM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mbpm assertion failed: same-cycle check");

// check that cons holds in the cycle after ante
`define MBPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mbpm assertion failed: next-cycle check");

`endif

// ===== rtl/core/mbpm_pkg.sv =====
// Shared types and constants of the masked byte pattern matcher
`default_nettype none

package mbpm_pkg;

   localparam int MAX_PATTERN  = 256;
   localparam int PAT_IDX_BITS = $clog2(MAX_PATTERN);
   localparam int OFFSET_BITS  = 48;
   localparam int LEN_BITS     = 9;
   localparam int BYTE_BITS    = 8;
   localparam int CMD_BITS     = 2;

   localparam int OP_DEPTH     = 4;
   localparam int OP_PTR_BITS  = $clog2(OP_DEPTH);
   localparam int OP_CNT_BITS  = OP_PTR_BITS + 1;

   localparam int RSP_DEPTH    = 2;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS = RSP_PTR_BITS + 1;

   localparam logic [CMD_BITS-1:0] CMD_DATA    = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_LOAD    = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_RESTART = 2'd2;

   typedef enum logic [1:0] {
      OP_DATA,
      OP_LOAD,
      OP_RESTART
   } op_kind_type;

   typedef struct packed {
      op_kind_type           kind;
      logic [BYTE_BITS-1:0]  data_byte;
      logic [BYTE_BITS-1:0]  entry_index;
      logic [BYTE_BITS-1:0]  entry_value;
      logic [BYTE_BITS-1:0]  entry_mask;
   } op_type;

endpackage

`default_nettype wire

// ===== rtl/core/mbpm_front.sv =====
// Front end: accept input transfers, classify commands, queue operations
`default_nettype none
`include "masked_byte_pattern_matcher_defines.svh"

module mbpm_front (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_push,
   output logic                                req_full,
   input  wire  [mbpm_pkg::CMD_BITS-1:0]       req_command,
   input  wire  [mbpm_pkg::BYTE_BITS-1:0]      req_data_byte,
   input  wire  [mbpm_pkg::BYTE_BITS-1:0]      req_entry_index,
   input  wire  [mbpm_pkg::BYTE_BITS-1:0]      req_entry_value,
   input  wire  [mbpm_pkg::BYTE_BITS-1:0]      req_entry_mask,
   output logic                                op_valid,
   output mbpm_pkg::op_type                    op,
   input  wire                                 op_pop
);

   mbpm_pkg::op_type                    op_q_ff [mbpm_pkg::OP_DEPTH];
   logic [mbpm_pkg::OP_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [mbpm_pkg::OP_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [mbpm_pkg::OP_CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                                accept;
   logic                                known;
   logic                                push_op;
   mbpm_pkg::op_type                    new_op;

   assign req_full = (cnt_ff == mbpm_pkg::OP_CNT_BITS'(mbpm_pkg::OP_DEPTH));
   assign accept   = req_push && !req_full;
   assign op_valid = (cnt_ff != '0);
   assign op       = op_q_ff[rd_ptr_ff];

   // classify; drop the unused command code
   always_comb begin
      new_op.data_byte   = req_data_byte;
      new_op.entry_index = req_entry_index;
      new_op.entry_value = req_entry_value;
      new_op.entry_mask  = req_entry_mask;
      known              = 1'b1;
      case (req_command)
         mbpm_pkg::CMD_DATA: begin
            new_op.kind = mbpm_pkg::OP_DATA;
         end
         mbpm_pkg::CMD_LOAD: begin
            new_op.kind = mbpm_pkg::OP_LOAD;
         end
         mbpm_pkg::CMD_RESTART: begin
            new_op.kind = mbpm_pkg::OP_RESTART;
         end
         default: begin
            new_op.kind = mbpm_pkg::OP_DATA;
            known       = 1'b0;
         end
      endcase
   end

   assign push_op = accept && known;

   always_comb begin
      wr_ptr_in = push_op ? wr_ptr_ff + mbpm_pkg::OP_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = op_pop  ? rd_ptr_ff + mbpm_pkg::OP_PTR_BITS'(1) : rd_ptr_ff;
      case ({push_op, op_pop})
         2'b10:   cnt_in = cnt_ff + mbpm_pkg::OP_CNT_BITS'(1);
         2'b01:   cnt_in = cnt_ff - mbpm_pkg::OP_CNT_BITS'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_op) begin
         op_q_ff[wr_ptr_ff] <= new_op;
      end
   end

   `MBPM_ASSERT_SAME(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= mbpm_pkg::OP_CNT_BITS'(mbpm_pkg::OP_DEPTH))
   `MBPM_ASSERT_SAME(a_pop_nonempty, clock, reset, op_pop, cnt_ff != '0)
   `MBPM_ASSERT_NEXT(a_cnt_grow, clock, reset, push_op && !op_pop, cnt_ff == $past(cnt_ff) + mbpm_pkg::OP_CNT_BITS'(1))

endmodule

`default_nettype wire

// ===== rtl/core/mbpm_back.sv =====
// Back end: pattern store, shift-and update, offset counter, match report
`default_nettype none
`include "masked_byte_pattern_matcher_defines.svh"

module mbpm_back (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_write_en,
   input  wire  [mbpm_pkg::LEN_BITS-1:0]       csr_pattern_length,
   input  wire                                 op_valid,
   input  wire  mbpm_pkg::op_type              op,
   output logic                                op_pop,
   output logic                                hit_push,
   output logic [mbpm_pkg::OFFSET_BITS-1:0]    hit_offset,
   input  wire                                 hit_full
);

   logic [mbpm_pkg::BYTE_BITS-1:0]      value_ff [mbpm_pkg::MAX_PATTERN];
   logic [mbpm_pkg::BYTE_BITS-1:0]      mask_ff  [mbpm_pkg::MAX_PATTERN];
   logic [mbpm_pkg::MAX_PATTERN-1:0]    prefix_ff, prefix_in;
   logic [mbpm_pkg::MAX_PATTERN-1:0]    fit;
   logic [mbpm_pkg::OFFSET_BITS-1:0]    bytes_seen_ff, bytes_seen_in;
   logic [mbpm_pkg::PAT_IDX_BITS-1:0]   last_idx_ff, last_idx_in;
   logic                                take;
   logic                                is_data;

   assign is_data = (op.kind == mbpm_pkg::OP_DATA);
   assign take    = op_valid && (!is_data || !hit_full);
   assign op_pop  = take;

   // clamp the length to 1..MAX_PATTERN and hold the index of its last entry
   always_comb begin
      if (csr_pattern_length == '0) begin
         last_idx_in = '0;
      end else if (csr_pattern_length > mbpm_pkg::LEN_BITS'(mbpm_pkg::MAX_PATTERN)) begin
         last_idx_in = mbpm_pkg::PAT_IDX_BITS'(mbpm_pkg::MAX_PATTERN - 1);
      end else begin
         last_idx_in = mbpm_pkg::PAT_IDX_BITS'(csr_pattern_length - mbpm_pkg::LEN_BITS'(1));
      end
   end

   always_comb begin
      for (int k = 0; k < mbpm_pkg::MAX_PATTERN; k++) begin
         fit[k] = ((op.data_byte & mask_ff[k]) == value_ff[k]);
      end
      prefix_in = {prefix_ff[mbpm_pkg::MAX_PATTERN-2:0], 1'b1} & fit;
   end

   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      if (take) begin
         case (op.kind)
            mbpm_pkg::OP_DATA:    bytes_seen_in = bytes_seen_ff + mbpm_pkg::OFFSET_BITS'(1);
            mbpm_pkg::OP_RESTART: bytes_seen_in = '0;
            default:              bytes_seen_in = bytes_seen_ff;
         endcase
      end
   end

   assign hit_push   = take && is_data && prefix_in[last_idx_ff];
   assign hit_offset = bytes_seen_ff - mbpm_pkg::OFFSET_BITS'(last_idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff     <= '0;
         bytes_seen_ff <= '0;
         last_idx_ff   <= '0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         if (csr_write_en) begin
            last_idx_ff <= last_idx_in;
         end
         if (take && is_data) begin
            prefix_ff <= prefix_in;
         end else if (take && op.kind == mbpm_pkg::OP_RESTART) begin
            prefix_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && op.kind == mbpm_pkg::OP_LOAD) begin
         value_ff[op.entry_index] <= op.entry_value;
         mask_ff[op.entry_index]  <= op.entry_mask;
      end
   end

   `MBPM_ASSERT_NEXT(a_restart_clears, clock, reset, take && op.kind == mbpm_pkg::OP_RESTART, bytes_seen_ff == '0 && prefix_ff == '0)
   `MBPM_ASSERT_SAME(a_hit_on_data, clock, reset, hit_push, take && is_data && !hit_full)
   `MBPM_ASSERT_NEXT(a_count_advance, clock, reset, take && is_data, bytes_seen_ff == $past(bytes_seen_ff) + mbpm_pkg::OFFSET_BITS'(1))

endmodule

`default_nettype wire

// ===== rtl/core/mbpm_rsp_queue.sv =====
// Result queue holding match offsets until the consumer transfers them
`default_nettype none

module mbpm_rsp_queue (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 push,
   input  wire  [mbpm_pkg::OFFSET_BITS-1:0]    push_offset,
   output logic                                full,
   input  wire                                 pop,
   output logic                                empty,
   output logic [mbpm_pkg::OFFSET_BITS-1:0]    head_offset
);

   logic [mbpm_pkg::OFFSET_BITS-1:0]    slot_ff [mbpm_pkg::RSP_DEPTH];
   logic [mbpm_pkg::RSP_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [mbpm_pkg::RSP_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [mbpm_pkg::RSP_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                                do_push;
   logic                                do_pop;

   assign full        = (cnt_ff == mbpm_pkg::RSP_CNT_BITS'(mbpm_pkg::RSP_DEPTH));
   assign empty       = (cnt_ff == '0);
   assign head_offset = slot_ff[rd_ptr_ff];
   assign do_push     = push && !full;
   assign do_pop      = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + mbpm_pkg::RSP_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + mbpm_pkg::RSP_PTR_BITS'(1) : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + mbpm_pkg::RSP_CNT_BITS'(1);
         2'b01:   cnt_in = cnt_ff - mbpm_pkg::RSP_CNT_BITS'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_offset;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/masked_byte_pattern_matcher.sv =====
// A byte transferred in is written to the operation queue; the back end takes it from there,
// compares all pattern entries at once in the shift-and update, and writes any match offset
// into the rsp_ result queue. Throughput: one item per cycle while the result queue has room.
// The operation queue (4 deep) and result queue (2 deep) let each side stall on its own.
// Reset (synchronous, active high) empties both queues, clears progress and the byte count,
// and sets the pattern length to 1; pattern entries are undefined until loaded.
`default_nettype none

module masked_byte_pattern_matcher (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_push,
   output logic                                req_full,
   input  wire  [mbpm_pkg::CMD_BITS-1:0]       req_command,
   input  wire  [mbpm_pkg::BYTE_BITS-1:0]      req_data_byte,
   input  wire  [mbpm_pkg::BYTE_BITS-1:0]      req_entry_index,
   input  wire  [mbpm_pkg::BYTE_BITS-1:0]      req_entry_value,
   input  wire  [mbpm_pkg::BYTE_BITS-1:0]      req_entry_mask,
   output logic                                rsp_empty,
   input  wire                                 rsp_pop,
   output logic [mbpm_pkg::OFFSET_BITS-1:0]    rsp_match_offset,
   input  wire                                 csr_write_en,
   input  wire  [mbpm_pkg::LEN_BITS-1:0]       csr_pattern_length
);

   logic                                op_valid;
   logic                                op_pop;
   mbpm_pkg::op_type                    op;
   logic                                hit_push;
   logic                                hit_full;
   logic [mbpm_pkg::OFFSET_BITS-1:0]    hit_offset;

   mbpm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_data_byte   (req_data_byte),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_entry_mask  (req_entry_mask),
      .op_valid        (op_valid),
      .op              (op),
      .op_pop          (op_pop)
   );

   mbpm_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_pattern_length (csr_pattern_length),
      .op_valid           (op_valid),
      .op                 (op),
      .op_pop             (op_pop),
      .hit_push           (hit_push),
      .hit_offset         (hit_offset),
      .hit_full           (hit_full)
   );

   mbpm_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (hit_push),
      .push_offset (hit_offset),
      .full        (hit_full),
      .pop         (rsp_pop),
      .empty       (rsp_empty),
      .head_offset (rsp_match_offset)
   );

endmodule

`default_nettype wire
